### hw/rtl/lcwf_pkg.sv
package lcwf_pkg;

  localparam int unsigned HISTORY_DEPTH = 65536;
  localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned LEN_W = 17;
  localparam int unsigned CNT_W = 16;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 17'h10000;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    PH_CMD     = 4'd0,
    PH_REL_OFS = 4'd1,
    PH_LITERAL = 4'd2,
    PH_ABS_LO  = 4'd3,
    PH_ABS_HI  = 4'd4,
    PH_FILL_CL = 4'd5,
    PH_FILL_CH = 4'd6,
    PH_FILL_V  = 4'd7,
    PH_LONG_CL = 4'd8,
    PH_LONG_CH = 4'd9,
    PH_LONG_PL = 4'd10,
    PH_LONG_PH = 4'd11,
    PH_RUN     = 4'd12
  } phase_e;

  typedef enum logic {
    KIND_COPY = 1'b0,
    KIND_FILL = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OFFSET    = 3'd1,
    ERR_UNWRITTEN = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_MISPLACED = 3'd4
  } err_e;

  typedef struct packed {
    logic             out_valid;
    logic [7:0]       out_byte;
    logic             run_pending;
    logic             finished;
    err_e             error_code;
    logic [LEN_W-1:0] decoded_length;
  } res_t;

  typedef struct packed {
    res_t               res;
    logic               from_ram;
    logic               we;
    logic [HIST_AW-1:0] waddr;
  } s1_t;

  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
    logic [7:0]         data;
  } wr_t;

  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
  } rd_t;

endpackage

### hw/rtl/lcwf_ram.sv
module lcwf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hw/rtl/lcwf_ctrl.sv
module lcwf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [16:0]           cfg_wdata_i,
  input  logic                  acc_i,
  input  logic [1:0]            op_i,
  input  logic [7:0]            byte_i,
  input  lcwf_pkg::wr_t         wr_i,
  output lcwf_pkg::rd_t         rd_o,
  output lcwf_pkg::s1_t         s1_o
);
  import lcwf_pkg::*;

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(HISTORY_DEPTH);

  phase_e             phase_q, phase_d;
  kind_e              kind_q, kind_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [15:0]        src_q, src_d;
  logic [7:0]         fill_q, fill_d;
  logic [LEN_W-1:0]   wpos_q, wpos_d;
  logic               done_q, done_d;
  err_e               err_q, err_d;
  logic [LEN_W-1:0]   limit_q;

  op_e                op;
  logic [LEN_W-1:0]   eff_limit;
  logic               full;
  logic [LEN_W-1:0]   ofs;
  logic [LEN_W-1:0]   back;
  logic [CNT_W-1:0]   cnt_dec;
  logic               valid;
  logic [7:0]         obyte;
  logic               from_ram;
  logic               we;

  assign op        = op_e'(op_i);
  assign eff_limit = (limit_q < DEPTH_L) ? limit_q : DEPTH_L;
  assign full      = (wpos_q >= eff_limit);
  assign ofs       = {5'b0, src_q[11:0] | {4'b0, byte_i}};
  assign back      = wpos_q - ofs;
  assign cnt_dec   = cnt_q - CNT_W'(1);

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    cnt_d    = cnt_q;
    src_d    = src_q;
    fill_d   = fill_q;
    wpos_d   = wpos_q;
    done_d   = done_q;
    err_d    = err_q;
    valid    = 1'b0;
    obyte    = 8'd0;
    from_ram = 1'b0;
    we       = 1'b0;
    rd_o     = '{en: 1'b0, addr: src_q[HIST_AW-1:0]};

    if (acc_i) begin
      case (op)
        OP_RESTART: begin
          phase_d = PH_CMD;
          kind_d  = KIND_COPY;
          cnt_d   = '0;
          src_d   = '0;
          fill_d  = '0;
          wpos_d  = '0;
          done_d  = 1'b0;
          err_d   = ERR_NONE;
        end
        OP_BYTE: begin
          if (err_q != ERR_NONE) begin
          end else if (done_q || phase_q == PH_RUN) begin
            err_d = ERR_MISPLACED;
          end else begin
            case (phase_q)
              PH_CMD: begin
                if (!byte_i[7]) begin
                  cnt_d   = CNT_W'(byte_i[6:4]) + CNT_W'(3);
                  src_d   = {4'b0, byte_i[3:0], 8'b0};
                  phase_d = PH_REL_OFS;
                end else if (!byte_i[6]) begin
                  if (byte_i[5:0] == 6'd0) begin
                    done_d = 1'b1;
                  end else begin
                    cnt_d   = CNT_W'(byte_i[5:0]);
                    phase_d = PH_LITERAL;
                  end
                end else if (byte_i[5:0] < 6'h3e) begin
                  cnt_d   = CNT_W'(byte_i[5:0]) + CNT_W'(3);
                  phase_d = PH_ABS_LO;
                end else if (byte_i[5:0] == 6'h3e) begin
                  phase_d = PH_FILL_CL;
                end else begin
                  phase_d = PH_LONG_CL;
                end
              end
              PH_REL_OFS: begin
                if (ofs > wpos_q) begin
                  err_d = ERR_OFFSET;
                end else begin
                  src_d   = back[15:0];
                  kind_d  = KIND_COPY;
                  phase_d = (cnt_q != '0) ? PH_RUN : PH_CMD;
                end
              end
              PH_LITERAL: begin
                if (full) begin
                  err_d = ERR_OVERFLOW;
                end else begin
                  valid   = 1'b1;
                  we      = 1'b1;
                  obyte   = byte_i;
                  wpos_d  = wpos_q + LEN_W'(1);
                  cnt_d   = cnt_dec;
                  if (cnt_dec == '0) begin
                    phase_d = PH_CMD;
                  end
                end
              end
              PH_ABS_LO, PH_LONG_PL: begin
                src_d   = {8'b0, byte_i};
                phase_d = (phase_q == PH_ABS_LO) ? PH_ABS_HI : PH_LONG_PH;
              end
              PH_ABS_HI, PH_LONG_PH: begin
                src_d   = {byte_i, src_q[7:0]};
                kind_d  = KIND_COPY;
                phase_d = (cnt_q != '0) ? PH_RUN : PH_CMD;
              end
              PH_FILL_CL, PH_LONG_CL: begin
                cnt_d   = {8'b0, byte_i};
                phase_d = (phase_q == PH_FILL_CL) ? PH_FILL_CH : PH_LONG_CH;
              end
              PH_FILL_CH: begin
                cnt_d   = {byte_i, cnt_q[7:0]};
                phase_d = PH_FILL_V;
              end
              PH_LONG_CH: begin
                cnt_d   = {byte_i, cnt_q[7:0]};
                phase_d = PH_LONG_PL;
              end
              PH_FILL_V: begin
                fill_d  = byte_i;
                kind_d  = KIND_FILL;
                phase_d = (cnt_q != '0) ? PH_RUN : PH_CMD;
              end
              default: begin
                err_d = ERR_MISPLACED;
              end
            endcase
          end
        end
        OP_TICK: begin
          if (err_q != ERR_NONE) begin
          end else if (done_q || phase_q != PH_RUN) begin
            err_d = ERR_MISPLACED;
          end else if (full) begin
            err_d = ERR_OVERFLOW;
          end else if (kind_q == KIND_FILL) begin
            valid  = 1'b1;
            we     = 1'b1;
            obyte  = fill_q;
            wpos_d = wpos_q + LEN_W'(1);
            cnt_d  = cnt_dec;
            if (cnt_dec == '0) begin
              phase_d = PH_CMD;
            end
          end else if ({1'b0, src_q} >= wpos_q || {1'b0, src_q} >= DEPTH_L) begin
            err_d = ERR_UNWRITTEN;
          end else begin
            valid   = 1'b1;
            we      = 1'b1;
            rd_o.en = 1'b1;
            // The byte written by the previous transaction lands in memory at
            // this same edge, so it is taken from the write port instead.
            if (wr_i.en && wr_i.addr == src_q[HIST_AW-1:0]) begin
              obyte = wr_i.data;
            end else begin
              from_ram = 1'b1;
            end
            src_d  = src_q + 16'd1;
            wpos_d = wpos_q + LEN_W'(1);
            cnt_d  = cnt_dec;
            if (cnt_dec == '0) begin
              phase_d = PH_CMD;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_o.res.out_valid      = valid;
    s1_o.res.out_byte       = obyte;
    s1_o.res.run_pending    = (err_d == ERR_NONE) && (phase_d == PH_RUN);
    s1_o.res.finished       = done_d;
    s1_o.res.error_code     = err_d;
    s1_o.res.decoded_length = wpos_d;
    s1_o.from_ram           = from_ram;
    s1_o.we                 = we;
    s1_o.waddr              = wpos_q[HIST_AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      kind_q  <= KIND_COPY;
      cnt_q   <= '0;
      src_q   <= '0;
      fill_q  <= '0;
      wpos_q  <= '0;
      done_q  <= 1'b0;
      err_q   <= ERR_NONE;
      limit_q <= LIMIT_RESET;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      src_q   <= src_d;
      fill_q  <= fill_d;
      wpos_q  <= wpos_d;
      done_q  <= done_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### hw/rtl/lcwf_pipe.sv
module lcwf_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  lcwf_pkg::s1_t   s1_i,
  input  logic [7:0]      rdata_i,
  input  logic            m_ready_i,
  output logic            in_ready_o,
  output lcwf_pkg::wr_t   wr_o,
  output logic            m_valid_o,
  output lcwf_pkg::res_t  m_res_o
);
  import lcwf_pkg::*;

  logic s1_valid_q, s1_valid_d;
  s1_t  s1_q;
  logic s2_valid_q, s2_valid_d;
  res_t s2_q, s1_res;
  logic s1_adv;

  assign s1_adv     = s1_valid_q && (!s2_valid_q || m_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    s1_res = s1_q.res;
    if (s1_q.from_ram) begin
      s1_res.out_byte = rdata_i;
    end
  end

  assign wr_o = '{en: s1_valid_q && s1_q.we && s1_adv, addr: s1_q.waddr,
                  data: s1_res.out_byte};

  assign s1_valid_d = acc_i || (s1_valid_q && !s1_adv);
  assign s2_valid_d = s1_adv || (s2_valid_q && !m_ready_i);
  assign m_valid_o  = s2_valid_q;
  assign m_res_o    = s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= s1_i;
    end
    if (s1_adv) begin
      s2_q <= s1_res;
    end
  end

endmodule

### hw/rtl/lcw_format80_decoder.sv
// Format80 stream decoder: one compressed byte, tick or restart per transaction.
// Two register stages, s1 and s2; s1 advances only while s2 is empty or being taken.
// Throughput: one transaction per cycle unless stalled, set by the single-port-read
// history memory and the two-register output path.
// Reset clears the parser, position, done flag and error and sets the output limit to 65536;
// history memory contents are not cleared and no clearing pass runs.
module lcw_format80_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte[7:0]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], run_pending[8], finished[9], error_code[12:10], decoded_length[29:13]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser   // out_valid
);
  import lcwf_pkg::*;

  logic       acc;
  wr_t        wr;
  rd_t        rd;
  s1_t        s1;
  res_t       res;
  logic [7:0] rdata;

  assign acc = s_axis_tvalid && s_axis_tready;

  lcwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .op_i        (s_axis_tuser),
    .byte_i      (s_axis_tdata),
    .wr_i        (wr),
    .rd_o        (rd),
    .s1_o        (s1)
  );

  lcwf_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.en),
    .raddr_i (rd.addr),
    .rdata_o (rdata)
  );

  lcwf_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .s1_i       (s1),
    .rdata_i    (rdata),
    .m_ready_i  (m_axis_tready),
    .in_ready_o (s_axis_tready),
    .wr_o       (wr),
    .m_valid_o  (m_axis_tvalid),
    .m_res_o    (res)
  );

  assign m_axis_tuser = res.out_valid;
  assign m_axis_tdata = {2'b0, res.decoded_length, res.error_code, res.finished,
                         res.run_pending, res.out_byte};

endmodule

### test/lcw_format80_decoder_tb.sv
`timescale 1ns / 1ps

module lcw_format80_decoder_tb;
  import lcwf_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [7:0] CMD_LITERAL   = 8'h80;
  localparam logic [7:0] CMD_END       = 8'h80;
  localparam logic [7:0] CMD_SHORT_ABS = 8'hC0;
  localparam logic [7:0] CMD_REPEAT    = 8'hFE;
  localparam logic [7:0] CMD_LONG      = 8'hFF;
  localparam logic [5:0] SEL_FILL      = 6'h3E;
  localparam int unsigned MAX_IDLE     = 18;
  localparam int unsigned OUTPUT_HOLD  = 250;
  localparam int unsigned STALL_LIMIT  = 3000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } item_t;

  class decode_scoreboard;
    res_t        pending_res[$];
    logic [7:0]  hist [HISTORY_DEPTH];
    phase_e      phase;
    kind_e       kind;
    err_e        err;
    logic [15:0] run_cnt;
    logic [15:0] src;
    logic [16:0] wpos;
    logic [16:0] limit;
    logic [7:0]  fill;
    logic [7:0]  tick_byte;
    logic        done;
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_bytes;
    int unsigned n_faulted;
    int unsigned n_bad;

    function new();
      limit = LIMIT_RESET;
      restart();
    endfunction

    function void restart();
      phase   = PH_CMD;
      kind    = KIND_COPY;
      err     = ERR_NONE;
      run_cnt = '0;
      src     = '0;
      wpos    = '0;
      fill    = '0;
      done    = 1'b0;
    endfunction

    function void flag_error(err_e code);
      if (err == ERR_NONE) err = code;
    endfunction

    function logic [16:0] room();
      return (limit < HISTORY_DEPTH) ? limit : 17'(HISTORY_DEPTH);
    endfunction

    function bit store_byte(logic [7:0] v);
      if (wpos >= room()) begin
        flag_error(ERR_OVERFLOW);
        return 1'b0;
      end
      hist[wpos[15:0]] = v;
      wpos++;
      return 1'b1;
    endfunction

    function void begin_run(kind_e k, logic [15:0] n);
      kind    = k;
      run_cnt = n;
      phase   = (n != 0) ? PH_RUN : PH_CMD;
    endfunction

    function void parse_command(logic [7:0] b);
      logic [5:0] c;
      c = b[5:0];
      if (!b[7]) begin
        run_cnt = 16'(b[6:4]) + 16'd3;
        src     = {4'h0, b[3:0], 8'h00};
        phase   = PH_REL_OFS;
      end else if (!b[6]) begin
        if (c == 0) begin
          done = 1'b1;
        end else begin
          run_cnt = 16'(c);
          phase   = PH_LITERAL;
        end
      end else if (c < SEL_FILL) begin
        run_cnt = 16'(c) + 16'd3;
        phase   = PH_ABS_LO;
      end else if (c == SEL_FILL) begin
        phase = PH_FILL_CL;
      end else begin
        phase = PH_LONG_CL;
      end
    endfunction

    function bit take_byte(logic [7:0] b);
      logic [15:0] ofs;
      bit          ok;
      ok = 1'b0;
      case (phase)
        PH_CMD: parse_command(b);
        PH_REL_OFS: begin
          ofs = src | 16'(b);
          if (17'(ofs) > wpos) begin
            flag_error(ERR_OFFSET);
          end else begin
            src = 16'(wpos - 17'(ofs));
            begin_run(KIND_COPY, run_cnt);
          end
        end
        PH_LITERAL: begin
          if (store_byte(b)) begin
            ok = 1'b1;
            run_cnt--;
            if (run_cnt == 0) phase = PH_CMD;
          end
        end
        PH_ABS_LO: begin
          src   = 16'(b);
          phase = PH_ABS_HI;
        end
        PH_ABS_HI: begin
          src[15:8] = b;
          begin_run(KIND_COPY, run_cnt);
        end
        PH_FILL_CL: begin
          run_cnt = 16'(b);
          phase   = PH_FILL_CH;
        end
        PH_FILL_CH: begin
          run_cnt[15:8] = b;
          phase         = PH_FILL_V;
        end
        PH_FILL_V: begin
          fill = b;
          begin_run(KIND_FILL, run_cnt);
        end
        PH_LONG_CL: begin
          run_cnt = 16'(b);
          phase   = PH_LONG_CH;
        end
        PH_LONG_CH: begin
          run_cnt[15:8] = b;
          phase         = PH_LONG_PL;
        end
        PH_LONG_PL: begin
          src   = 16'(b);
          phase = PH_LONG_PH;
        end
        PH_LONG_PH: begin
          src[15:8] = b;
          begin_run(KIND_COPY, run_cnt);
        end
        default: flag_error(ERR_MISPLACED);
      endcase
      return ok;
    endfunction

    function bit take_tick();
      if (wpos >= room()) begin
        flag_error(ERR_OVERFLOW);
        return 1'b0;
      end
      if (kind == KIND_FILL) begin
        tick_byte = fill;
      end else begin
        if (17'(src) >= wpos) begin
          flag_error(ERR_UNWRITTEN);
          return 1'b0;
        end
        tick_byte = hist[src];
        src++;
      end
      void'(store_byte(tick_byte));
      run_cnt--;
      if (run_cnt == 0) phase = PH_CMD;
      return 1'b1;
    endfunction

    function res_t decode_item(logic [1:0] op, logic [7:0] b);
      res_t r;
      r = '0;
      if (op == OP_RESTART) begin
        restart();
      end else if (op != OP_UNUSED && err == ERR_NONE) begin
        if (op == OP_BYTE) begin
          if (done || phase == PH_RUN) begin
            flag_error(ERR_MISPLACED);
          end else if (take_byte(b)) begin
            r.out_valid = 1'b1;
            r.out_byte  = b;
          end
        end else begin
          if (done || phase != PH_RUN) begin
            flag_error(ERR_MISPLACED);
          end else if (take_tick()) begin
            r.out_valid = 1'b1;
            r.out_byte  = tick_byte;
          end
        end
      end
      r.run_pending    = (err == ERR_NONE && phase == PH_RUN);
      r.finished       = done;
      r.error_code     = err;
      r.decoded_length = wpos;
      return r;
    endfunction

    function void accept_item(logic [1:0] op, logic [7:0] b);
      pending_res.push_back(decode_item(op, b));
      n_items++;
    endfunction

    function void note_bad(string what, res_t want, res_t seen);
      n_bad++;
      if (n_bad <= 10) begin
        $display("%0t: %s at result %0d", $realtime, what, n_results);
        $display("  expected valid=%0b byte=%02h pending=%0b finished=%0b error=%0d length=%0d",
                 want.out_valid, want.out_byte, want.run_pending, want.finished,
                 want.error_code, want.decoded_length);
        $display("  actual   valid=%0b byte=%02h pending=%0b finished=%0b error=%0d length=%0d",
                 seen.out_valid, seen.out_byte, seen.run_pending, seen.finished,
                 seen.error_code, seen.decoded_length);
      end
    endfunction

    function void check_result(logic [31:0] data, logic flag);
      res_t seen;
      res_t want;
      seen.out_valid      = flag;
      seen.out_byte       = data[7:0];
      seen.run_pending    = data[8];
      seen.finished       = data[9];
      seen.error_code     = err_e'(data[12:10]);
      seen.decoded_length = data[29:13];
      n_results++;
      if (pending_res.size() == 0) begin
        note_bad("result with nothing outstanding", seen, seen);
        return;
      end
      want = pending_res.pop_front();
      if (seen.out_valid !== want.out_valid || seen.out_byte !== want.out_byte ||
          seen.run_pending !== want.run_pending || seen.finished !== want.finished ||
          seen.error_code !== want.error_code ||
          seen.decoded_length !== want.decoded_length) begin
        note_bad("result mismatch", want, seen);
      end
      if (want.out_valid) n_bytes++;
      if (want.error_code != ERR_NONE) n_faulted++;
    endfunction

    function void close_out();
      n_bad += pending_res.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  decode_scoreboard sb;
  item_t            stim_q[$];
  int unsigned      gen_pos;
  int unsigned      gen_limit = 65536;
  int unsigned      n_limits = 1;
  int unsigned      quiet_cycles;
  bit               send_calm;
  bit               recv_calm;
  bit               hold_output;

  lcw_format80_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) sb.accept_item(s_axis_tuser, s_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
      if (hold_output) begin
        hold_output = 1'b0;
        stall = OUTPUT_HOLD;
      end else begin
        stall = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  function automatic void push(logic [1:0] op, logic [7:0] data);
    stim_q.push_back({op, data});
  endfunction

  function automatic bit add_ticks(int unsigned cnt);
    int unsigned n;
    bit          cut;
    cut = (gen_pos + cnt > gen_limit);
    n = cut ? gen_limit - gen_pos + 1 : cnt;
    repeat (n) push(OP_TICK, 8'($urandom));
    gen_pos += n;
    return cut;
  endfunction

  function automatic int unsigned draw_count();
    if (gen_limit < 1000 && $urandom_range(0, 2) == 0) return $urandom_range(0, 65535);
    return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
  endfunction

  function automatic void add_fault();
    int unsigned ofs;
    int unsigned cnt;
    logic [2:0]  rel_cnt;
    rel_cnt = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: begin
        ofs = (gen_pos < 4095) ? $urandom_range(gen_pos + 1, 4095) : 4095;
        push(OP_BYTE, {1'b0, rel_cnt, ofs[11:8]});
        push(OP_BYTE, ofs[7:0]);
        push(OP_TICK, 8'($urandom));
      end
      1: begin
        push(OP_BYTE, {1'b0, rel_cnt, 4'h0});
        push(OP_BYTE, 8'h00);
        push(OP_TICK, 8'($urandom));
      end
      2: push(OP_TICK, 8'($urandom));
      3: begin
        cnt = $urandom_range(2, 5);
        push(OP_BYTE, CMD_REPEAT);
        push(OP_BYTE, cnt[7:0]);
        push(OP_BYTE, 8'h00);
        push(OP_BYTE, 8'($urandom));
        repeat (cnt - 1) push(OP_TICK, 8'($urandom));
        push(OP_BYTE, 8'($urandom));
      end
      4: repeat ($urandom_range(1, 8)) push(2'($urandom_range(0, 3)), 8'($urandom));
      default: begin
        ofs = $urandom_range(0, gen_pos - 1);
        push(OP_BYTE, CMD_LONG);
        push(OP_BYTE, 8'd6);
        push(OP_BYTE, 8'd0);
        push(OP_BYTE, ofs[7:0]);
        push(OP_BYTE, ofs[15:8]);
        repeat (2) push(OP_TICK, 8'($urandom));
      end
    endcase
  endfunction

  function automatic void add_stream(int unsigned n_cmds);
    int unsigned k;
    int unsigned sel;
    int unsigned c;
    int unsigned cnt;
    int unsigned ofs;
    int unsigned hi;
    logic [2:0]  rel_cnt;
    push(OP_RESTART, 8'($urandom));
    gen_pos = 0;
    for (k = 0; k < n_cmds; k++) begin
      if (gen_pos != 0 && $urandom_range(0, 19) == 0) begin
        add_fault();
        return;
      end
      sel = (gen_pos == 0) ? 0 : $urandom_range(0, 5);
      case (sel)
        0, 1: begin
          c = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
          push(OP_BYTE, CMD_LITERAL | c[7:0]);
          repeat (c) push(OP_BYTE, 8'($urandom));
          gen_pos += c;
          if (gen_pos > gen_limit) return;
        end
        2: begin
          rel_cnt = 3'($urandom_range(0, 7));
          hi = (gen_pos < 4095) ? gen_pos : 4095;
          if ($urandom_range(0, 1) == 0 && hi > 8) hi = 8;
          ofs = $urandom_range(1, hi);
          push(OP_BYTE, {1'b0, rel_cnt, ofs[11:8]});
          push(OP_BYTE, ofs[7:0]);
          if (add_ticks(rel_cnt + 3)) return;
        end
        3: begin
          c = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 61) : $urandom_range(0, 6);
          ofs = $urandom_range(0, gen_pos - 1);
          push(OP_BYTE, CMD_SHORT_ABS | c[7:0]);
          push(OP_BYTE, ofs[7:0]);
          push(OP_BYTE, ofs[15:8]);
          if (add_ticks(c + 3)) return;
        end
        4: begin
          cnt = draw_count();
          push(OP_BYTE, CMD_REPEAT);
          push(OP_BYTE, cnt[7:0]);
          push(OP_BYTE, cnt[15:8]);
          push(OP_BYTE, 8'($urandom));
          if (add_ticks(cnt)) return;
        end
        default: begin
          cnt = draw_count();
          ofs = $urandom_range(0, gen_pos - 1);
          push(OP_BYTE, CMD_LONG);
          push(OP_BYTE, cnt[7:0]);
          push(OP_BYTE, cnt[15:8]);
          push(OP_BYTE, ofs[7:0]);
          push(OP_BYTE, ofs[15:8]);
          if (add_ticks(cnt)) return;
        end
      endcase
    end
    case ($urandom_range(0, 5))
      0: push(OP_UNUSED, 8'($urandom));
      1: begin
        push(OP_BYTE, CMD_END);
        push(OP_BYTE, 8'($urandom));
      end
      2: begin
        push(OP_BYTE, CMD_END);
        push(OP_TICK, 8'($urandom));
      end
      default: push(OP_BYTE, CMD_END);
    endcase
  endfunction

  function automatic void add_directed();
    push(OP_BYTE, CMD_LITERAL | 8'd3);
    push(OP_BYTE, 8'h00);
    push(OP_BYTE, 8'hFF);
    push(OP_BYTE, 8'hA5);
    // A relative copy whose source runs into the bytes it is writing.
    push(OP_BYTE, 8'h00);
    push(OP_BYTE, 8'h02);
    repeat (3) push(OP_TICK, 8'h00);
    push(OP_BYTE, CMD_SHORT_ABS);
    push(OP_BYTE, 8'h01);
    push(OP_BYTE, 8'h00);
    repeat (3) push(OP_TICK, 8'hFF);
    push(OP_BYTE, CMD_REPEAT);
    push(OP_BYTE, 8'h02);
    push(OP_BYTE, 8'h00);
    push(OP_BYTE, 8'h5A);
    repeat (2) push(OP_TICK, 8'h00);
    push(OP_BYTE, CMD_REPEAT);
    push(OP_BYTE, 8'h00);
    push(OP_BYTE, 8'h00);
    push(OP_BYTE, 8'h77);
    push(OP_BYTE, CMD_LONG);
    push(OP_BYTE, 8'h02);
    push(OP_BYTE, 8'h00);
    push(OP_BYTE, 8'h00);
    push(OP_BYTE, 8'h00);
    repeat (2) push(OP_TICK, 8'h00);
    push(OP_UNUSED, 8'hFF);
    push(OP_BYTE, CMD_END);
    push(OP_BYTE, 8'h11);
  endfunction

  function automatic void fill_queue(int unsigned target, int unsigned max_cmds);
    while (stim_q.size() < target) add_stream($urandom_range(1, max_cmds));
  endfunction

  task automatic send_item(logic [1:0] op, logic [7:0] data, bit no_gap);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = (no_gap || send_calm) ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drive_queue(bit pressure);
    item_t       it;
    int unsigned burst_left;
    burst_left = pressure ? 400 : 0;
    if (pressure) hold_output = 1'b1;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      send_item(it.op, it.data, burst_left != 0);
      if (burst_left != 0) burst_left--;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic program_limit(logic [16:0] value);
    while (sb.pending_res.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    sb.limit  = value;
    gen_limit = value;
    n_limits++;
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_directed();
    fill_queue(600, 12);
    drive_queue(1'b1);

    program_limit(17'd1);
    fill_queue(60, 3);
    drive_queue(1'b0);

    program_limit(17'd45);
    fill_queue(200, 8);
    drive_queue(1'b0);

    program_limit(17'($urandom_range(100, 60000)));
    fill_queue(300, 12);
    drive_queue(1'b0);

    program_limit(LIMIT_RESET);
    fill_queue(350, 16);
    drive_queue(1'b0);

    while (sb.pending_res.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.close_out();
    $display("Run covered %0d input transactions and %0d results under %0d output limits.",
             sb.n_items, sb.n_results, n_limits);
    $display("%0d results carried a decoded byte, %0d an error code; %0d mismatches.",
             sb.n_bytes, sb.n_faulted, sb.n_bad);
    if (sb.n_bad == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### lcw_format80_decoder.f
hw/rtl/lcwf_pkg.sv
hw/rtl/lcwf_ram.sv
hw/rtl/lcwf_ctrl.sv
hw/rtl/lcwf_pipe.sv
hw/rtl/lcw_format80_decoder.sv
test/lcw_format80_decoder_tb.sv
